FILE: hw/rtl/hrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, constants and helpers for the heading-relative radar plot.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int FRAC_BITS     = 16;
    localparam int LEVEL_BAND    = 128;
    localparam int SCALE_MIN     = 4;
    localparam int SCALE_MAX     = 128;
    localparam int SCREEN_LIMIT  = 255;

    // 1/K of the CORDIC in Q30
    localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;

    // datapath widths
    localparam int VW = 36;   // vectoring x/y, Q16 world units plus growth
    localparam int RW = 28;   // rotation x/y, Q16 pixels plus growth
    localparam int ZW = 34;   // rotation residual angle

    // radius divider: quotient bits and bits retired per stage
    localparam int Q_BITS      = 24;
    localparam int DIV_PER     = 4;
    localparam int DIV_STAGES  = Q_BITS / DIV_PER;

    // pipeline stage positions
    localparam int IDX_M1  = CORDIC_STAGES + 1;
    localparam int IDX_M2  = CORDIC_STAGES + 2;
    localparam int IDX_DS  = CORDIC_STAGES + 3;
    localparam int IDX_MK  = IDX_DS + DIV_STAGES + 1;
    localparam int IDX_P   = IDX_MK + 1;
    localparam int LAT     = IDX_P + CORDIC_STAGES + 1;

    // radius limit times scale after reset (64 pixels, scale 32)
    localparam logic [31:0] RESET_LIM = 32'd64 * 32'd65536 * 32'd32;

    localparam logic [7:0] SCALE_RESET  = 8'd32;
    localparam logic [7:0] RADIUS_RESET = 8'd64;

    typedef enum logic {
        REG_PLOT_SCALE = 1'b0,
        REG_MAX_RADIUS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        MARK_LEVEL = 2'd0,
        MARK_ABOVE = 2'd1,
        MARK_BELOW = 2'd2
    } marker_t;

    typedef struct packed {
        logic [31:0]        ang;
        logic signed [16:0] hd;
        marker_t            kind;
    } side_t;

    // atan(2^-i) in 2^32-per-turn units
    localparam logic [31:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Q16 to whole pixels, toward zero, clamped to the screen limit
    function automatic logic signed [8:0] trunc_pix(input logic signed [RW-1:0] v);
        logic [RW-1:0] mag;
        logic [RW-FRAC_BITS-1:0] whole;
        logic [8:0] lim;
        mag   = v[RW-1] ? RW'(-v) : RW'(v);
        whole = mag[RW-1:FRAC_BITS];
        lim   = (whole > (RW-FRAC_BITS)'(SCREEN_LIMIT)) ? 9'(SCREEN_LIMIT) : whole[8:0];
        return v[RW-1] ? 9'(-lim) : lim;
    endfunction

endpackage

FILE: hw/rtl/heading_relative_radar_plot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_relative_radar_plot
// Plots an object on a heading-up radar dial: CORDIC bearing and range,
// radius scaling with saturation, CORDIC rotation into screen offsets.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that start is high; busy never rises.
// Each transaction returns exactly one result, shown with done for one cycle,
// in order. The result passes through the two unrolled CORDIC pipelines
// (one iteration per stage), the split range multiplier and the radius
// divider that retires four quotient bits per stage. Results cannot be held
// off, so the downstream side must take one per cycle. Write the plot scale
// and max_radius only while no transaction is in flight.
module heading_relative_radar_plot (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                wr_en,
    input  logic                wr_index,
    input  logic [7:0]          wr_data,
    input  logic signed [15:0]  viewer_x,
    input  logic signed [15:0]  viewer_y,
    input  logic signed [15:0]  viewer_z,
    input  logic signed [15:0]  object_x,
    input  logic signed [15:0]  object_y,
    input  logic signed [15:0]  object_z,
    input  logic [15:0]         heading,
    output logic                done,
    output logic signed [8:0]   screen_dx,
    output logic signed [8:0]   screen_dy,
    output logic signed [16:0]  height_diff,
    output logic [1:0]          marker_kind
);
    import hrp_pkg::*;

    localparam int CS = CORDIC_STAGES;

    logic [7:0]  scale_reg;
    logic [7:0]  radius_reg;
    logic [31:0] lim_reg;
    logic [7:0]  scale_eff;

    logic        v_reg [0:LAT];
    side_t       side_reg [0:LAT-1];

    logic signed [VW-1:0] vx_reg [0:CS];
    logic signed [VW-1:0] vy_reg [0:CS];
    logic [31:0]          vb_reg [0:CS];

    logic [47:0] plo_reg;
    logic [47:0] phi_reg;
    logic [35:0] len_reg;
    logic [65:0] len_sum;

    logic [7:0]        rem_reg  [0:DIV_STAGES];
    logic [Q_BITS-1:0] dvd_reg  [0:DIV_STAGES];
    logic [Q_BITS-1:0] q_reg    [0:DIV_STAGES];
    logic              sat_reg  [0:DIV_STAGES];
    logic [7:0]        rem_next [0:DIV_STAGES-1];
    logic [Q_BITS-1:0] dvd_next [0:DIV_STAGES-1];
    logic [Q_BITS-1:0] q_next   [0:DIV_STAGES-1];

    logic [Q_BITS-1:0] rq;
    logic [53:0]       prod_reg;

    logic signed [RW-1:0] rx_reg [0:CS];
    logic signed [RW-1:0] ry_reg [0:CS];
    logic signed [ZW-1:0] rz_reg [0:CS];

    logic signed [16:0] dx_in, dy_in, xn_in, yn_in, hd_in;
    marker_t            kind_in;
    logic [31:0]        off_in;
    logic signed [RW-1:0] rx_in;

    logic signed [8:0]  dx_reg, dy_reg;
    logic signed [16:0] hd_reg;
    marker_t            kind_reg;

    assign busy = 1'b0;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            radius_reg <= RADIUS_RESET;
            lim_reg    <= RESET_LIM;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (reg_index_t'(wr_index))
                    REG_PLOT_SCALE: scale_reg  <= wr_data;
                    REG_MAX_RADIUS: radius_reg <= wr_data;
                endcase
            end
            lim_reg <= 32'({radius_reg, 16'h0}) * 32'(scale_eff);
        end
    end

    always_comb
    begin
        if (scale_reg < 8'(SCALE_MIN))
            scale_eff = 8'(SCALE_MIN);
        else if (scale_reg > 8'(SCALE_MAX))
            scale_eff = 8'(SCALE_MAX);
        else
            scale_eff = scale_reg;
    end

    // ---------------------------------------------------------------- valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAT; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= start && !busy;
            for (int k = 1; k <= LAT; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // ---------------------------------------------------------------- entry
    always_comb
    begin
        dx_in = 17'(object_x) - 17'(viewer_x);
        dy_in = 17'(object_y) - 17'(viewer_y);
        hd_in = 17'(viewer_z) - 17'(object_z);
        // fold the left half plane over
        xn_in = dx_in[16] ? -dx_in : dx_in;
        yn_in = dx_in[16] ? -dy_in : dy_in;
        if (hd_in <= -17'(LEVEL_BAND))
            kind_in = MARK_ABOVE;
        else if (hd_in >= 17'(LEVEL_BAND))
            kind_in = MARK_BELOW;
        else
            kind_in = MARK_LEVEL;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0].ang  <= {heading, 16'h0};
        side_reg[0].hd   <= hd_in;
        side_reg[0].kind <= kind_in;
        for (int k = 1; k < LAT; k++)
        begin
            if (k == IDX_M1)
            begin
                // replace heading with heading minus bearing once bearing is known
                side_reg[k].ang  <= side_reg[k-1].ang - vb_reg[CS];
                side_reg[k].hd   <= side_reg[k-1].hd;
                side_reg[k].kind <= side_reg[k-1].kind;
            end
            else
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ---------------------------------------------------------------- vectoring
    always_ff @(posedge clk)
    begin
        vx_reg[0] <= VW'($signed({xn_in, 16'h0}));
        vy_reg[0] <= VW'($signed({yn_in, 16'h0}));
        vb_reg[0] <= dx_in[16] ? 32'h80000000 : 32'h0;
        for (int i = 0; i < CS; i++)
        begin
            if (!vy_reg[i][VW-1])
            begin
                vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                vb_reg[i+1] <= vb_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                vb_reg[i+1] <= vb_reg[i] - ATAN_TAB[i];
            end
        end
    end

    // ---------------------------------------------------------------- range
    assign len_sum = {phi_reg, 18'h0} + {18'h0, plo_reg};

    always_ff @(posedge clk)
    begin
        plo_reg <= 48'(vx_reg[CS][17:0]) * 48'(GAIN_INV_Q30);
        phi_reg <= 48'(vx_reg[CS][35:18]) * 48'(GAIN_INV_Q30);
        len_reg <= len_sum[65:30];
    end

    // ---------------------------------------------------------------- divider
    always_comb
    begin
        logic [8:0]        t;
        logic [7:0]        r;
        logic [Q_BITS-1:0] d;
        logic [Q_BITS-1:0] qq;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            r  = rem_reg[j];
            d  = dvd_reg[j];
            qq = q_reg[j];
            for (int k = 0; k < DIV_PER; k++)
            begin
                t = {r, d[Q_BITS-1]};
                d = {d[Q_BITS-2:0], 1'b0};
                if (t >= {1'b0, scale_eff})
                begin
                    r  = 8'(t - {1'b0, scale_eff});
                    qq = {qq[Q_BITS-2:0], 1'b1};
                end
                else
                begin
                    r  = t[7:0];
                    qq = {qq[Q_BITS-2:0], 1'b0};
                end
            end
            rem_next[j] = r;
            dvd_next[j] = d;
            q_next[j]   = qq;
        end
    end

    always_ff @(posedge clk)
    begin
        // below the limit the quotient fits Q_BITS and the top bits are < scale
        sat_reg[0] <= (len_reg >= {4'h0, lim_reg});
        rem_reg[0] <= len_reg[31:24];
        dvd_reg[0] <= len_reg[23:0];
        q_reg[0]   <= '0;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            rem_reg[j+1] <= rem_next[j];
            dvd_reg[j+1] <= dvd_next[j];
            q_reg[j+1]   <= q_next[j];
            sat_reg[j+1] <= sat_reg[j];
        end
    end

    // ---------------------------------------------------------------- radius
    assign rq = sat_reg[DIV_STAGES] ? {radius_reg, 16'h0} : q_reg[DIV_STAGES];

    always_ff @(posedge clk)
    begin
        prod_reg <= 54'(rq) * 54'(GAIN_INV_Q30);
    end

    // ---------------------------------------------------------------- rotation
    always_comb
    begin
        off_in = side_reg[IDX_P-1].ang;
        rx_in  = RW'(prod_reg[53:30]);
        // back half: rotate by half a turn first
        if (off_in[31] ^ off_in[30])
        begin
            rx_in  = -rx_in;
            off_in = off_in ^ 32'h80000000;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0] <= rx_in;
        ry_reg[0] <= '0;
        rz_reg[0] <= ZW'($signed(off_in));
        for (int i = 0; i < CS; i++)
        begin
            if (!rz_reg[i][ZW-1])
            begin
                rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                rz_reg[i+1] <= rz_reg[i] - $signed(ZW'(ATAN_TAB[i]));
            end
            else
            begin
                rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                rz_reg[i+1] <= rz_reg[i] + $signed(ZW'(ATAN_TAB[i]));
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk)
    begin
        dx_reg   <= trunc_pix(ry_reg[CS]);
        dy_reg   <= trunc_pix(-rx_reg[CS]);
        hd_reg   <= side_reg[LAT-1].hd;
        kind_reg <= side_reg[LAT-1].kind;
    end

    assign done        = v_reg[LAT];
    assign screen_dx   = dx_reg;
    assign screen_dy   = dy_reg;
    assign height_diff = hd_reg;
    assign marker_kind = kind_reg;

    // ---------------------------------------------------------------- checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LAT+1) done)
        else $error("result missing after fixed latency");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT+1))
        else $error("result without a transaction");

    a_screen_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (screen_dx != -9'sd256 && screen_dy != -9'sd256))
        else $error("screen offset out of range");

    a_level_band: assert property (@(posedge clk) disable iff (!rst_n)
        (done && marker_kind == MARK_LEVEL) |->
            (height_diff > -17'sd128 && height_diff < 17'sd128))
        else $error("level marker outside band");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Radar plot check: drives viewer/object/heading transactions and register
// writes, predicts each plotted point in SystemVerilog and compares results.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic signed [16:0] hd;
    logic [1:0]         kind;
} plot_point_t;

class plot_scoreboard;
    plot_point_t pending[$];
    int          n_bad;
    int          n_seen;
    logic [7:0]  scale_reg;
    logic [7:0]  radius_reg;

    function new();
        n_bad      = 0;
        n_seen     = 0;
        scale_reg  = 8'd32;
        radius_reg = 8'd64;
    endfunction

    static function longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    static function longint to_pix(longint v);
        longint r;
        r = (v < 0) ? -((-v) >>> 16) : (v >>> 16);
        if (r > 255) r = 255;
        if (r < -255) r = -255;
        return r;
    endfunction

    function plot_point_t predict_point(logic signed [15:0] vx, logic signed [15:0] vy,
                                        logic signed [15:0] vz, logic signed [15:0] ox,
                                        logic signed [15:0] oy, logic signed [15:0] oz,
                                        logic [15:0] hdg);
        longint      x, y, xs, ys, z, t, hdiff;
        longint unsigned len, rq, rlim, sc;
        logic [31:0] brg, off;
        plot_point_t p;
        x   = (longint'(ox) - longint'(vx)) * 65536;
        y   = (longint'(oy) - longint'(vy)) * 65536;
        brg = 32'd0;
        if (x < 0)
        begin
            x   = -x;
            y   = -y;
            brg = 32'h8000_0000;
        end
        for (int i = 0; i < hrp_pkg::CORDIC_STAGES; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; brg = brg + hrp_pkg::ATAN_TAB[i];
            end
            else
            begin
                x = x - ys; y = y + xs; brg = brg - hrp_pkg::ATAN_TAB[i];
            end
        end
        len = (longint'(x) * longint'(hrp_pkg::GAIN_INV_Q30)) >> 30;
        sc  = scale_reg;
        if (sc < hrp_pkg::SCALE_MIN) sc = hrp_pkg::SCALE_MIN;
        if (sc > hrp_pkg::SCALE_MAX) sc = hrp_pkg::SCALE_MAX;
        rq   = len / sc;
        rlim = longint'(radius_reg) << 16;
        if (rq > rlim) rq = rlim;
        off = {hdg, 16'd0} - brg;
        x   = longint'((rq * longint'(hrp_pkg::GAIN_INV_Q30)) >> 30);
        y   = 0;
        // fold back half of the circle into the CORDIC range
        if (off[31:30] == 2'd1 || off[31:30] == 2'd2)
        begin
            x   = -x;
            off = off - 32'h8000_0000;
        end
        z = longint'(signed'(off));
        for (int i = 0; i < hrp_pkg::CORDIC_STAGES; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (z >= 0)
            begin
                t = x - ys; y = y + xs; x = t; z = z - longint'(hrp_pkg::ATAN_TAB[i]);
            end
            else
            begin
                t = x + ys; y = y - xs; x = t; z = z + longint'(hrp_pkg::ATAN_TAB[i]);
            end
        end
        hdiff = longint'(vz) - longint'(oz);
        p.dx  = 9'(to_pix(y));
        p.dy  = 9'(to_pix(-x));
        p.hd  = 17'(hdiff);
        if (hdiff > -hrp_pkg::LEVEL_BAND && hdiff < hrp_pkg::LEVEL_BAND)
            p.kind = hrp_pkg::MARK_LEVEL;
        else if (hdiff <= -hrp_pkg::LEVEL_BAND)
            p.kind = hrp_pkg::MARK_ABOVE;
        else
            p.kind = hrp_pkg::MARK_BELOW;
        return p;
    endfunction

    function void note_input(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [15:0] vz, logic signed [15:0] ox,
                             logic signed [15:0] oy, logic signed [15:0] oz,
                             logic [15:0] hdg);
        pending.push_back(predict_point(vx, vy, vz, ox, oy, oz, hdg));
    endfunction

    function void check_result(plot_point_t got);
        plot_point_t want;
        n_seen++;
        if (pending.size() == 0)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("ERROR: unexpected result dx=%0d dy=%0d", got.dx, got.dy);
            return;
        end
        want = pending.pop_front();
        if (got.dx !== want.dx || got.dy !== want.dy || got.hd !== want.hd
            || got.kind !== want.kind)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("ERROR: exp dx=%0d dy=%0d hd=%0d k=%0d got dx=%0d dy=%0d hd=%0d k=%0d",
                         want.dx, want.dy, want.hd, want.kind,
                         got.dx, got.dy, got.hd, got.kind);
        end
    endfunction
endclass

module tb_top;
    import hrp_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               wr_en = 1'b0;
    logic               wr_index = 1'b0;
    logic [7:0]         wr_data = 8'd0;
    logic signed [15:0] viewer_x = '0, viewer_y = '0, viewer_z = '0;
    logic signed [15:0] object_x = '0, object_y = '0, object_z = '0;
    logic [15:0]        heading = '0;
    logic               done;
    logic signed [8:0]  screen_dx, screen_dy;
    logic signed [16:0] height_diff;
    logic [1:0]         marker_kind;

    plot_scoreboard sb;
    int             idle_cycles = 0;
    int             n_sent = 0;
    bit             no_gaps = 1'b0;

    heading_relative_radar_plot dut (.*);

    always #4 clk = ~clk;

    // sample results and count cycles without any transaction
    always @(posedge clk)
    begin
        plot_point_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.dx   = screen_dx;
                got.dy   = screen_dy;
                got.hd   = height_diff;
                got.kind = marker_kind;
                sb.check_result(got);
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_index_t idx, logic [7:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_PLOT_SCALE)
            sb.scale_reg = val;
        else
            sb.radius_reg = val;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    task automatic send_point(logic signed [15:0] vx, logic signed [15:0] vy,
                              logic signed [15:0] vz, logic signed [15:0] ox,
                              logic signed [15:0] oy, logic signed [15:0] oz,
                              logic [15:0] hdg);
        while (!no_gaps && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        viewer_x <= vx; viewer_y <= vy; viewer_z <= vz;
        object_x <= ox; object_y <= oy; object_z <= oz;
        heading  <= hdg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(vx, vy, vz, ox, oy, oz, hdg);
        n_sent++;
    endtask

    task automatic send_random(int mode);
        logic signed [15:0] vx, vy, ox, oy;
        int span;
        vx = 16'($urandom);
        vy = 16'($urandom);
        // mostly keep the object near the viewer so the dial is not always pinned
        if (mode == 0)
        begin
            span = 1 << $urandom_range(15, 4);
            ox = vx + 16'($urandom_range(2 * span) - span);
            oy = vy + 16'($urandom_range(2 * span) - span);
        end
        else
        begin
            ox = 16'($urandom);
            oy = 16'($urandom);
        end
        send_point(vx, vy, 16'($urandom), ox, oy,
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400) - 200),
                   16'($urandom));
    endtask

    task automatic end_phase();
        start <= 1'b0;
        @(posedge clk);
        drain();
    endtask

    initial
    begin
        logic [7:0] scales[4];
        logic [7:0] radii[4];
        scales = '{8'd0, 8'd4, 8'd128, 8'd255};
        radii  = '{8'd0, 8'd1, 8'd255, 8'd100};
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero difference, each quadrant, marker bands
        no_gaps = 1'b1;
        send_point(0, 0, 0, 0, 0, 0, 0);
        send_point(100, 100, 5, 100, 100, 5, 16'hFFFF);
        send_point(-32768, -32768, -32768, 32767, 32767, 32767, 16'h0000);
        send_point(32767, 32767, 32767, -32768, -32768, -32768, 16'h8000);
        send_point(0, 0, 127, 1000, 0, 0, 16'h4000);
        send_point(0, 0, 128, 0, 1000, 0, 16'hC000);
        send_point(0, 0, -127, -1000, 0, 0, 16'h2000);
        send_point(0, 0, -128, 0, -1000, 0, 16'h6000);
        send_point(0, 0, 0, -700, -900, 129, 16'hA000);
        send_point(0, 0, 0, 700, -900, -129, 16'hE000);
        send_point(0, 0, 0, 1, 1, 0, 16'h1234);
        send_point(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5A5A);
        no_gaps = 1'b0;
        end_phase();

        // register sweep including clamp and zero-radius corners
        foreach (scales[i])
        begin
            write_reg(REG_PLOT_SCALE, scales[i]);
            write_reg(REG_MAX_RADIUS, radii[i]);
            repeat (30) send_random($urandom_range(3) == 0);
            end_phase();
        end

        // long random stretch; first part back to back
        write_reg(REG_PLOT_SCALE, 8'($urandom_range(255)));
        write_reg(REG_MAX_RADIUS, 8'($urandom_range(255)));
        no_gaps = 1'b1;
        repeat (120) send_random(0);
        no_gaps = 1'b0;
        repeat (120) send_random($urandom_range(3) == 0);
        end_phase();
        write_reg(REG_PLOT_SCALE, 8'd32);
        write_reg(REG_MAX_RADIUS, 8'd64);
        repeat (130) send_random($urandom_range(3) == 0);
        end_phase();

        $display("Sent %0d radar points over several scale/radius settings, %0d results checked.",
                 n_sent, sb.n_seen);
        if (sb.n_bad == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
